// ===== design/hex_text_to_bytes_macros.svh =====
// assertion macros for the hex text to bytes decoder
// used by hex_text_to_bytes.sv, expects clk and rst_n in scope
`ifndef HEX_TEXT_TO_BYTES_MACROS_SVH
`define HEX_TEXT_TO_BYTES_MACROS_SVH

// same-cycle implication, checked outside reset
`define HTB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define HTB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/htb_pkg.sv =====
// shared types, codes and character decode for the hex text to bytes decoder
// no dependencies
package htb_pkg;

  localparam int CHAR_W = 8;
  localparam int NIB_W  = 4;
  localparam int KIND_W = 2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OK    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RSVD  = 2'd3;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_USCR  = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;

  localparam logic [NIB_W-1:0] NIB_TEN = 4'd10;

  // one buffered result
  typedef struct packed {
    logic [CHAR_W-1:0] data;
    logic [KIND_W-1:0] kind;
    logic              last;
  } res_t;

  typedef struct packed {
    logic             ok;
    logic [NIB_W-1:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [CHAR_W-1:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      h.val = NIB_W'(c - CH_ZERO);
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      h.val = NIB_W'(c - CH_LO_A) + NIB_TEN;
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      h.val = NIB_W'(c - CH_UP_A) + NIB_TEN;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic is_skip(input logic [CHAR_W-1:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
           c == CH_FF || c == CH_CR || c == CH_COMMA || c == CH_HASH ||
           c == CH_USCR;
  endfunction

endpackage

// ===== design/hex_text_to_bytes.sv =====
// hex text to bytes decoder: one ascii character in, up to two results out
// depends on htb_pkg and hex_text_to_bytes_macros.svh
//
//   channel | ports          | tdata        | tuser | tlast
//   --------+----------------+--------------+-------+-----------
//   input   | in_t*          | character    | -     | final_req
//   result  | out_t*         | data_byte    | kind  | last
//
// one character per cycle unless in_tready is held low; decode and state update
// finish in the accept cycle and the results land in a two-entry result buffer
// a character that yields two results holds in_tready low while the first
// result drains; an output stall backs up into in_tready
// rst_n is synchronous, active low, and clears the decode state and buffer
`include "hex_text_to_bytes_macros.svh"

module hex_text_to_bytes (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [htb_pkg::CHAR_W-1:0]    in_tdata,   // [7:0] character
  input  logic                          in_tlast,   // final_req
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [htb_pkg::CHAR_W-1:0]    out_tdata,  // [7:0] data_byte
  output logic [htb_pkg::KIND_W-1:0]    out_tuser,  // [1:0] kind
  output logic                          out_tlast   // last
);
  import htb_pkg::*;

  // decode state
  logic [NIB_W-1:0] hi_r, hi_nxt;
  logic             have_r, have_nxt;
  logic             pz_r, pz_nxt;
  logic             err_r, err_nxt;

  // result buffer
  res_t       slot0_r, slot0_nxt;
  res_t       slot1_r, slot1_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  logic in_xfer, out_xfer;

  // results of the current character
  logic [CHAR_W-1:0] rd [2];
  logic [KIND_W-1:0] rk [2];
  logic [1:0]        rc;
  logic [NIB_W-1:0]  hi_c;
  logic              have_c, pz_c, err_c;

  assign in_tready  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_tready);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_xfer   = out_tvalid && out_tready;
  assign out_tdata  = slot0_r.data;
  assign out_tuser  = slot0_r.kind;
  assign out_tlast  = slot0_r.last;

  always_comb begin
    hex_t h;
    logic consumed;
    logic failed;
    h        = hex_decode(in_tdata);
    consumed = 1'b0;
    failed   = 1'b0;
    hi_c     = hi_r;
    have_c   = have_r;
    pz_c     = pz_r;
    err_c    = err_r;
    rc       = 2'd0;
    rd[0]    = '0;
    rd[1]    = '0;
    rk[0]    = KIND_BYTE;
    rk[1]    = KIND_BYTE;
    if (!err_r) begin
      // held zero: either the x of a prefix follows or it counts as a digit
      if (pz_r) begin
        pz_c = 1'b0;
        if (in_tdata == CH_LO_X || in_tdata == CH_UP_X) begin
          consumed = 1'b1;
        end else if (have_c) begin
          rd[rc[0]] = {hi_c, {NIB_W{1'b0}}};
          rk[rc[0]] = KIND_BYTE;
          rc        = rc + 2'd1;
          hi_c      = '0;
          have_c    = 1'b0;
        end else begin
          hi_c   = '0;
          have_c = 1'b1;
        end
      end
      if (!consumed) begin
        if (is_skip(in_tdata)) begin
          pz_c = pz_c;
        end else if (in_tdata == CH_ZERO) begin
          pz_c = 1'b1;
        end else if (h.ok) begin
          if (have_c) begin
            rd[rc[0]] = {hi_c, h.val};
            rk[rc[0]] = KIND_BYTE;
            rc        = rc + 2'd1;
            hi_c      = '0;
            have_c    = 1'b0;
          end else begin
            hi_c   = h.val;
            have_c = 1'b1;
          end
        end else begin
          rd[rc[0]] = '0;
          rk[rc[0]] = KIND_ERROR;
          rc        = rc + 2'd1;
          err_c     = 1'b1;
          failed    = 1'b1;
          hi_c      = '0;
          have_c    = 1'b0;
        end
      end
      if (in_tlast && !failed) begin
        // a zero still held at the end counts as a digit
        if (pz_c) begin
          pz_c = 1'b0;
          if (have_c) begin
            rd[rc[0]] = {hi_c, {NIB_W{1'b0}}};
            rk[rc[0]] = KIND_BYTE;
            rc        = rc + 2'd1;
            hi_c      = '0;
            have_c    = 1'b0;
          end else begin
            hi_c   = '0;
            have_c = 1'b1;
          end
        end
        rd[rc[0]] = '0;
        rk[rc[0]] = have_c ? KIND_ERROR : KIND_OK;
        rc        = rc + 2'd1;
      end
    end
  end

  always_comb begin
    hi_nxt    = hi_r;
    have_nxt  = have_r;
    pz_nxt    = pz_r;
    err_nxt   = err_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    if (in_xfer) begin
      if (in_tlast) begin
        hi_nxt   = '0;
        have_nxt = 1'b0;
        pz_nxt   = 1'b0;
        err_nxt  = 1'b0;
      end else begin
        hi_nxt   = hi_c;
        have_nxt = have_c;
        pz_nxt   = pz_c;
        err_nxt  = err_c;
      end
      // a transfer in only happens when the buffer is empty or drains this cycle
      slot0_nxt = '{data: rd[0], kind: rk[0], last: (rc == 2'd1)};
      slot1_nxt = '{data: rd[1], kind: rk[1], last: 1'b1};
      cnt_nxt   = rc;
    end else if (out_xfer) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r   <= '0;
      have_r <= 1'b0;
      pz_r   <= 1'b0;
      err_r  <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      hi_r   <= hi_nxt;
      have_r <= have_nxt;
      pz_r   <= pz_nxt;
      err_r  <= err_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  `HTB_ASSERT_NEXT(a_final_clears, in_xfer && in_tlast, !have_r && !pz_r && !err_r && hi_r == '0, "decode state not cleared after final character")
  `HTB_ASSERT_IMPL(a_pair_order, cnt_r == 2'd2, !slot0_r.last && slot1_r.last, "two buffered results with wrong last marks")
  `HTB_ASSERT_IMPL(a_kind_legal, out_tvalid, out_tuser != KIND_RSVD, "reserved result kind")
  `HTB_ASSERT_IMPL(a_status_zero, out_tvalid && out_tuser != KIND_BYTE, out_tdata == '0, "status result carries nonzero data")

endmodule

// ===== test/hex_text_to_bytes_tb.sv =====
`timescale 1ns / 1ps
// testbench for hex_text_to_bytes: directed strings, then random hex strings and noise
// under several idle/stall patterns, checked against a predictor in a scoreboard class
// depends on htb_pkg and the hex_text_to_bytes rtl
module hex_text_to_bytes_tb;
  import htb_pkg::*;

  localparam int ITEMS_PER_PHASE = 385;
  localparam int QUIET_LIMIT     = 2000;
  localparam int TAIL_CYCLES     = 20;

  // decoder state shadow and queue of results still owed by the block
  class hex_byte_scoreboard;
    res_t             expected_results[$];
    res_t             step_results[$];
    logic [NIB_W-1:0] high_nib;
    bit               have_nib;
    bit               zero_held;
    bit               in_error;
    int               fail_count;

    function void clear_state();
      high_nib  = '0;
      have_nib  = 1'b0;
      zero_held = 1'b0;
      in_error  = 1'b0;
    endfunction

    function int digit_value(logic [CHAR_W-1:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
      if (c >= CH_LO_A && c <= CH_LO_F) return int'(c - CH_LO_A) + 10;
      if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
      return -1;
    endfunction

    function bit is_filler(logic [CHAR_W-1:0] c);
      return c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR,
                       CH_COMMA, CH_HASH, CH_USCR};
    endfunction

    function void emit(logic [CHAR_W-1:0] data, logic [KIND_W-1:0] kind);
      res_t r;
      r.data = data;
      r.kind = kind;
      r.last = 1'b0;
      step_results.push_back(r);
    endfunction

    function void take_nibble(logic [NIB_W-1:0] nib);
      if (have_nib) begin
        emit({high_nib, nib}, KIND_BYTE);
        high_nib = '0;
        have_nib = 1'b0;
      end else begin
        high_nib = nib;
        have_nib = 1'b1;
      end
    endfunction

    // predict the results of one accepted character
    function void note_char(logic [CHAR_W-1:0] c, logic fin);
      bit   consumed;
      bit   failed;
      int   v;
      res_t r;
      consumed = 1'b0;
      failed   = 1'b0;
      step_results.delete();
      if (!in_error) begin
        if (zero_held) begin
          zero_held = 1'b0;
          // 0x / 0X prefix swallows the held zero
          if (c == CH_LO_X || c == CH_UP_X) consumed = 1'b1;
          else take_nibble('0);
        end
        if (!consumed && !is_filler(c)) begin
          v = digit_value(c);
          if (c == CH_ZERO) begin
            zero_held = 1'b1;
          end else if (v >= 0) begin
            take_nibble(v[NIB_W-1:0]);
          end else begin
            emit('0, KIND_ERROR);
            in_error = 1'b1;
            failed   = 1'b1;
            high_nib = '0;
            have_nib = 1'b0;
          end
        end
        if (fin && !failed) begin
          if (zero_held) begin
            zero_held = 1'b0;
            take_nibble('0);
          end
          emit('0, have_nib ? KIND_ERROR : KIND_OK);
        end
      end
      if (fin) clear_state();
      foreach (step_results[i]) begin
        r      = step_results[i];
        r.last = (i == step_results.size() - 1);
        expected_results.push_back(r);
      end
    endfunction

    function void check_result(logic [CHAR_W-1:0] data, logic [KIND_W-1:0] kind,
                               logic last);
      res_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result data=%h kind=%0d last=%0d",
                 $time, data, kind, last);
        fail_count++;
        return;
      end
      want = expected_results.pop_front();
      if (data !== want.data || kind !== want.kind || last !== want.last) begin
        $display("%0t: mismatch expected data=%h kind=%0d last=%0d, got data=%h kind=%0d last=%0d",
                 $time, want.data, want.kind, want.last, data, kind, last);
        fail_count++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [CHAR_W-1:0] in_tdata;
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [CHAR_W-1:0] out_tdata;
  logic [KIND_W-1:0] out_tuser;
  logic              out_tlast;

  hex_byte_scoreboard sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int chars_sent     = 0;
  int quiet_cycles   = 0;

  hex_text_to_bytes dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // transfer monitor, prediction, checking and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_char(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  task automatic send_char(logic [CHAR_W-1:0] c, logic fin);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = c;
    in_tlast  = fin;
    do @(posedge clk); while (!in_tready);
    chars_sent++;
  endtask

  task automatic send_text(string s, bit ends);
    for (int i = 0; i < s.len(); i++) send_char(s[i], ends && (i == s.len() - 1));
  endtask

  // hold the sender until every owed result has come out
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CHAR_W-1:0] digit_char(int v);
    if (v < 10) return CH_ZERO + CHAR_W'(v);
    return ($urandom_range(1) ? CH_LO_A : CH_UP_A) + CHAR_W'(v - 10);
  endfunction

  function automatic logic [CHAR_W-1:0] filler_char();
    case ($urandom_range(8))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      3:       return CH_VT;
      4:       return CH_FF;
      5:       return CH_CR;
      6:       return CH_COMMA;
      7:       return CH_HASH;
      default: return CH_USCR;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] bad_char();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(255));
    while (sb.digit_value(c) >= 0 || sb.is_filler(c));
    return c;
  endfunction

  task automatic send_random_string();
    logic [CHAR_W-1:0] text[$];
    if ($urandom_range(9) == 0) begin
      // raw noise, any byte value
      repeat ($urandom_range(8, 1)) text.push_back(CHAR_W'($urandom_range(255)));
    end else begin
      if ($urandom_range(1)) begin
        text.push_back(CH_ZERO);
        text.push_back($urandom_range(1) ? CH_LO_X : CH_UP_X);
      end
      repeat ($urandom_range(6)) begin
        if ($urandom_range(4) == 0) text.push_back(filler_char());
        text.push_back(digit_char($urandom_range(15)));
        // prefix in the low nibble place
        if ($urandom_range(11) == 0) begin
          text.push_back(CH_ZERO);
          text.push_back($urandom_range(1) ? CH_LO_X : CH_UP_X);
        end
        text.push_back(digit_char($urandom_range(15)));
      end
      if ($urandom_range(9) == 0) text.push_back(digit_char($urandom_range(15)));
      if ($urandom_range(9) == 0) text.insert($urandom_range(text.size()), bad_char());
      if (text.size() == 0) text.push_back(filler_char());
    end
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  initial begin
    int idle_pcts[4];
    int stall_pcts[4];
    idle_pcts  = '{0, 84, 0, 25};
    stall_pcts = '{0, 0, 84, 25};
    sb = new();
    sb.clear_state();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_text("0xA5f0", 1);
    send_text("a0X1\t_", 1);
    // held zero completes a byte before the error, then the rest is ignored
    send_text("a0g", 0);
    send_char(8'hFF, 1'b0);
    send_text("B", 1);
    send_char(8'h80, 1'b1);
    send_text("7\r", 1);
    send_char(CH_FF, 1'b0);
    send_char(CH_VT, 1'b0);
    send_text("00", 1);
    send_char(8'h00, 1'b1);
    drain();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_pcts[p];
      recv_stall_pct = stall_pcts[p];
      while (chars_sent < 25 + (p + 1) * ITEMS_PER_PHASE) send_random_string();
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.fail_count == 0 && sb.expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      if (sb.expected_results.size() != 0)
        $display("%0t: %0d expected results never arrived", $time,
                 sb.expected_results.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/htb_pkg.sv
design/hex_text_to_bytes.sv
test/hex_text_to_bytes_tb.sv
